// ===== rtl/core/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants for the run-length pattern decoder.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int SYMBOL_W = 8;
  localparam int RUN_W    = 16;
  localparam int CFG_W    = 15;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [SYMBOL_W-1:0] CH_EOL  = 8'h24;  // '$'
  localparam logic [SYMBOL_W-1:0] CH_END  = 8'h21;  // '!'
  localparam logic [SYMBOL_W-1:0] CH_DEAD = 8'h62;  // 'b'
  localparam logic [SYMBOL_W-1:0] CH_LIVE = 8'h6F;  // 'o'
  localparam logic [SYMBOL_W-1:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [SYMBOL_W-1:0] CH_NINE = 8'h39;  // '9'

  localparam logic [CFG_W-1:0] GRID_LIMIT_RESET = 15'h7FFF;

  typedef enum logic [1:0] {
    CFG_GRID_LIMIT     = 2'd0,
    CFG_PATTERN_WIDTH  = 2'd1,
    CFG_PATTERN_HEIGHT = 2'd2
  } cfg_index_t;

endpackage

// ===== rtl/core/lrd_sym_if.sv =====
// ----------------------------------------------------------------------------
// lrd_sym_if
// Symbol channel: one pattern character per beat, with a restart mark.
// ----------------------------------------------------------------------------
interface lrd_sym_if;

  logic                         valid;
  logic                         ready;
  logic [lrd_pkg::SYMBOL_W-1:0] symbol;
  logic                         restart;

  modport source (output valid, output symbol, output restart, input ready);
  modport sink   (input valid, input symbol, input restart, output ready);

endinterface

// ===== rtl/core/lrd_run_if.sv =====
// ----------------------------------------------------------------------------
// lrd_run_if
// Run channel: one live run (x, y, length) per beat.
// ----------------------------------------------------------------------------
interface lrd_run_if;

  logic                             valid;
  logic                             ready;
  logic        [lrd_pkg::RUN_W-1:0] run_x;
  logic signed [lrd_pkg::RUN_W-1:0] run_y;
  logic        [lrd_pkg::RUN_W-1:0] run_length;

  modport source (output valid, output run_x, output run_y, output run_length, input ready);
  modport sink   (input valid, input run_x, input run_y, input run_length, output ready);

endinterface

// ===== rtl/core/life_rle_pattern_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// life_rle_pattern_decoder_unit
// Run-length cell pattern decoder: characters in, live runs out.
// ----------------------------------------------------------------------------
// Usage:
//   symbols : one character per beat; restart marks the first character of a
//             pattern and reloads the cursor from pattern_height.
//   runs    : one beat per emitted live run (start x, row y, length).
//   cfg_*   : grid_limit, pattern_width, pattern_height; write while idle.
// Timing: a character is registered on its beat and decoded in the next
//   cycle; its run (if any) is loaded into the run register at the following
//   edge, so a run beat passes the input register and then the run register.
//   One character per cycle is sustained while runs are taken; while a run
//   waits, one more character can still enter the decode stage.
// Stall: when runs.ready is low and a run is held, the decode stage holds
//   and symbols.ready drops once that stage is full too.
// Reset: the decoder waits in the finished state, ignoring characters until a
//   restart; grid_limit returns to its maximum, width and height to zero.
// ----------------------------------------------------------------------------
module life_rle_pattern_decoder_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  lrd_pkg::cfg_index_t        cfg_index,
  input  logic [lrd_pkg::CFG_W-1:0]  cfg_data,
  lrd_sym_if.sink                    symbols,
  lrd_run_if.source                  runs
);

  import lrd_pkg::*;

  localparam int WW = COORD_BITS + 17;
  localparam logic signed [WW-1:0] YMAX = {{18{1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [WW-1:0] YMIN = {{18{1'b1}}, {(COORD_BITS-1){1'b0}}};
  localparam logic        [WW-1:0] XMAX = {{17{1'b0}}, {COORD_BITS{1'b1}}};

  logic [CFG_W-1:0] grid_limit;
  logic [CFG_W-1:0] pattern_width;
  logic [CFG_W-1:0] pattern_height;

  logic                         stage_valid;
  logic [SYMBOL_W-1:0]          stage_symbol;
  logic                         stage_restart;

  logic [COORD_BITS-1:0]        x_reg;
  logic signed [COORD_BITS-1:0] y_reg;
  logic [COUNT_W-1:0]           repeat_count;
  logic                         in_number;
  logic                         finished;
  logic                         rejected;

  logic [COORD_BITS-1:0]        x_next;
  logic signed [COORD_BITS-1:0] y_next;
  logic [COUNT_W-1:0]           repeat_count_next;
  logic                         in_number_next;
  logic                         finished_next;
  logic                         rejected_next;

  logic                         out_valid;
  logic [RUN_W-1:0]             run_x;
  logic signed [RUN_W-1:0]      run_y;
  logic [RUN_W-1:0]             run_length;

  logic                         out_free;
  logic                         stage_advance;
  logic                         emit;

  logic [COORD_BITS-1:0]        x_eff;
  logic signed [COORD_BITS-1:0] y_eff;
  logic [COUNT_W-1:0]           cnt_eff;
  logic                         innum_eff;
  logic                         fin_eff;
  logic                         rej_eff;

  logic signed [WW-1:0]         height_w;
  logic signed [WW-1:0]         y_w;
  logic signed [WW-1:0]         y_diff;
  logic [WW-1:0]                x_sum;
  logic [COORD_BITS-1:0]        x_adv;
  logic [SYMBOL_W-1:0]          digit_full;
  logic [19:0]                  count10;

  assign out_free      = !out_valid || runs.ready;
  assign stage_advance = stage_valid && out_free;
  assign symbols.ready = !stage_valid || out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_limit     <= GRID_LIMIT_RESET;
      pattern_width  <= '0;
      pattern_height <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_LIMIT:     grid_limit     <= cfg_data;
        CFG_PATTERN_WIDTH:  pattern_width  <= cfg_data;
        CFG_PATTERN_HEIGHT: pattern_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (symbols.ready) begin
      stage_valid <= symbols.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (symbols.valid && symbols.ready) begin
      stage_symbol  <= symbols.symbol;
      stage_restart <= symbols.restart;
    end
  end

  // decode
  always_comb begin
    height_w = {{(WW-CFG_W){1'b0}}, pattern_height};
    if (stage_restart) begin
      x_eff     = '0;
      y_eff     = (height_w > YMAX) ? YMAX[COORD_BITS-1:0] : height_w[COORD_BITS-1:0];
      cnt_eff   = COUNT_W'(1);
      innum_eff = 1'b0;
      fin_eff   = 1'b0;
      rej_eff   = (pattern_width > grid_limit) || (pattern_height > grid_limit);
    end else begin
      x_eff     = x_reg;
      y_eff     = y_reg;
      cnt_eff   = repeat_count;
      innum_eff = in_number;
      fin_eff   = finished;
      rej_eff   = rejected;
    end

    digit_full = stage_symbol - CH_ZERO;
    count10    = ({4'b0, cnt_eff} << 3) + ({4'b0, cnt_eff} << 1) + {16'b0, digit_full[3:0]};

    x_sum = {{(WW-COORD_BITS){1'b0}}, x_eff} + {{(WW-COUNT_W){1'b0}}, cnt_eff};
    x_adv = (x_sum > XMAX) ? XMAX[COORD_BITS-1:0] : x_sum[COORD_BITS-1:0];

    y_w    = {{(WW-COORD_BITS){y_eff[COORD_BITS-1]}}, y_eff};
    y_diff = y_w - $signed({{(WW-COUNT_W){1'b0}}, cnt_eff});

    x_next            = x_eff;
    y_next            = y_eff;
    repeat_count_next = cnt_eff;
    in_number_next    = innum_eff;
    finished_next     = fin_eff;
    rejected_next     = rej_eff;
    emit              = 1'b0;

    if (!fin_eff && !rej_eff) begin
      if (stage_symbol inside {[CH_ZERO:CH_NINE]}) begin
        in_number_next = 1'b1;
        if (!innum_eff) begin
          repeat_count_next = {{(COUNT_W-4){1'b0}}, digit_full[3:0]};
        end else if (count10 > {4'b0, COUNT_MAX}) begin
          repeat_count_next = COUNT_MAX;
        end else begin
          repeat_count_next = count10[COUNT_W-1:0];
        end
      end else begin
        in_number_next = 1'b0;
        case (stage_symbol)
          CH_EOL: begin
            y_next            = (y_diff < YMIN) ? YMIN[COORD_BITS-1:0] : y_diff[COORD_BITS-1:0];
            x_next            = '0;
            repeat_count_next = COUNT_W'(1);
          end
          CH_END: begin
            finished_next = 1'b1;
          end
          CH_DEAD: begin
            x_next            = x_adv;
            repeat_count_next = COUNT_W'(1);
          end
          CH_LIVE: begin
            emit              = (cnt_eff != '0);
            x_next            = x_adv;
            repeat_count_next = COUNT_W'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      x_reg        <= '0;
      y_reg        <= '0;
      repeat_count <= COUNT_W'(1);
      in_number    <= 1'b0;
      finished     <= 1'b1;
      rejected     <= 1'b0;
    end else if (stage_advance) begin
      x_reg        <= x_next;
      y_reg        <= y_next;
      repeat_count <= repeat_count_next;
      in_number    <= in_number_next;
      finished     <= finished_next;
      rejected     <= rejected_next;
    end
  end

  // run register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && emit) begin
      run_x      <= x_sum[RUN_W-1:0] - cnt_eff;
      run_y      <= y_w[RUN_W-1:0];
      run_length <= cnt_eff;
    end
  end

  assign runs.valid      = out_valid;
  assign runs.run_x      = run_x;
  assign runs.run_y      = run_y;
  assign runs.run_length = run_length;

endmodule
